### design/tme_pkg.sv
// Shared constants, opcode codes and result type for the tape machine executor.
package tme_pkg;

	// Program store depth. Load addresses at or beyond it are dropped.
	localparam int PROG_DEPTH = 4096;
	// Tape depth in cells. Must be a power of two: pointer arithmetic wraps by truncation.
	localparam int TAPE_DEPTH = 32768;

	localparam int PA_W    = $clog2(PROG_DEPTH);
	localparam int PC_W    = $clog2(PROG_DEPTH + 1);
	localparam int CP_W    = $clog2(TAPE_DEPTH);
	localparam int LEN_W   = 13;
	localparam int ADDR_W  = 12;
	localparam int ARG_W   = 15;
	localparam int OPC_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int INSTR_W = OPC_W + ARG_W;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [OPC_W-1:0] {
		OP_NOP        = 4'd0,
		OP_ADD        = 4'd1,
		OP_SUB        = 4'd2,
		OP_SET        = 4'd3,
		OP_GOTO       = 4'd4,
		OP_RIGHT      = 4'd5,
		OP_LEFT       = 4'd6,
		OP_LOOP_START = 4'd7,
		OP_LOOP_END   = 4'd8,
		OP_WRITE      = 4'd9,
		OP_READ       = 4'd10
	} opcode_t;

	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              took_input;
		logic              halted;
		logic [LEN_W-1:0]  next_pc;
	} result_t;

endpackage

### design/tme_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/tme_out_buf.sv
// Two-entry result buffer: holds finished results while the receiver stalls.
module tme_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tme_pkg::result_t push_data,
	input  logic             pop_ready,
	output logic             head_valid,
	output tme_pkg::result_t head_data,
	output logic             full
);
	import tme_pkg::*;

	logic    head_v_q;
	logic    skid_v_q;
	result_t head_q;
	result_t skid_q;
	logic    pop;

	assign pop        = head_v_q && pop_ready;
	assign head_valid = head_v_q;
	assign head_data  = head_q;
	assign full       = head_v_q && skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (head_v_q && !pop) begin
			// Head held: park a new result behind it.
			if (push) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			// Advance skid into head, refill skid from the push side.
			head_v_q <= 1'b1;
			skid_v_q <= push;
		end else begin
			head_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (head_v_q && !pop) begin
			if (push) begin
				skid_q <= push_data;
			end
		end else if (skid_v_q) begin
			head_q <= skid_q;
			skid_q <= push_data;
		end else begin
			head_q <= push_data;
		end
	end

endmodule

### design/tape_machine_executor.sv
// Top level of the tape machine executor: program store, tape, and step execution.
//
// Requests arrive on in_valid/in_ready: cmd selects a load (write opcode and
// operand to program memory at load_address) or a step (run the instruction at
// the program counter; in_byte feeds a read instruction). Every request yields
// one result on res_valid/res_ready: out_valid/out_byte for a write, took_input
// for a read, halted and next_pc after the request. cfg_we/cfg_wdata write
// program_length; write it only while no request is in flight.
// Timing: at the accepting edge both memories are read at the current counter
// and pointer; the next cycle executes and writes back, and the result is
// offered on res_valid from the edge after that. A new request is not taken
// while the last one executes; this is set by the read-modify-write loop through
// the tape memory and the counter/pointer registers.
// Reset: arst_n clears counter, pointer and length, then a clearing pass zeroes
// the tape one cell per cycle (all TAPE_DEPTH cells, 32768 by default) with
// in_ready low. Config writes are taken during the pass.
// Stall: a two-entry output buffer holds results; requests keep flowing until
// both entries are full, then in_ready drops until the receiver takes one.
module tape_machine_executor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tme_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic [tme_pkg::ADDR_W-1:0] load_address,
	input  logic [tme_pkg::OPC_W-1:0]  opcode,
	input  logic [tme_pkg::ARG_W-1:0]  operand,
	input  logic [tme_pkg::BYTE_W-1:0] in_byte,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       out_valid,
	output logic [tme_pkg::BYTE_W-1:0] out_byte,
	output logic                       took_input,
	output logic                       halted,
	output logic [tme_pkg::LEN_W-1:0]  next_pc
);
	import tme_pkg::*;

	// Control state
	logic              clr_busy_q;
	logic [CP_W-1:0]   clr_cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [PC_W-1:0]   pc_q;
	logic [CP_W-1:0]   cp_q;
	logic              v_s1;

	// Request payload, one stage behind acceptance
	logic              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [OPC_W-1:0]  opcode_s1;
	logic [ARG_W-1:0]  operand_s1;
	logic [BYTE_W-1:0] in_byte_s1;

	logic              accept;
	logic              buf_full;
	logic [INSTR_W-1:0] prog_rdata;
	logic              prog_we;
	logic [BYTE_W-1:0] tape_rdata;
	logic              tape_we;
	logic [CP_W-1:0]   tape_waddr;
	logic [BYTE_W-1:0] tape_wdata;

	logic [PC_W-1:0]   eff_len;
	logic              run;
	opcode_t           op;
	logic [ARG_W-1:0]  arg;
	logic [CP_W-1:0]   vm;
	logic [ARG_W:0]    tgt;
	logic [BYTE_W-1:0] cell_new;
	logic              cell_we;
	logic [CP_W-1:0]   cp_new;
	logic              jump;
	logic              emit;
	logic              took;
	logic [PC_W-1:0]   pc_new;
	logic [PC_W-1:0]   pc_after;
	result_t           res_s1;
	result_t           res_head;

	assign accept   = in_valid && in_ready;
	assign in_ready = !clr_busy_q && !v_s1 && !buf_full;

	// Program length saturated to the store depth
	assign eff_len = (32'(len_q) > PROG_DEPTH) ? PC_W'(PROG_DEPTH) : PC_W'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			len_q      <= '0;
			pc_q       <= '0;
			cp_q       <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CP_W'(TAPE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			v_s1 <= accept;
			if (run) begin
				pc_q <= pc_new;
				cp_q <= cp_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			addr_s1    <= load_address;
			opcode_s1  <= opcode;
			operand_s1 <= operand;
			in_byte_s1 <= in_byte;
		end
	end

	// Program store: written by loads in stage 1, read at the counter on accept
	assign prog_we = v_s1 && (cmd_s1 == CMD_LOAD) && (32'(addr_s1) < PROG_DEPTH);

	tme_ram #(
		.WIDTH(INSTR_W),
		.DEPTH(PROG_DEPTH)
	) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (PA_W'(addr_s1)),
		.wdata ({opcode_s1, operand_s1}),
		.raddr (pc_q[PA_W-1:0]),
		.rdata (prog_rdata)
	);

	// Tape: the clearing pass owns the write port until it finishes
	always_comb begin
		if (clr_busy_q) begin
			tape_we    = 1'b1;
			tape_waddr = clr_cnt_q;
			tape_wdata = '0;
		end else begin
			tape_we    = run && cell_we;
			tape_waddr = cp_q;
			tape_wdata = cell_new;
		end
	end

	tme_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TAPE_DEPTH)
	) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (cp_q),
		.rdata (tape_rdata)
	);

	// Execute the fetched instruction against the fetched cell
	assign run = v_s1 && (cmd_s1 == CMD_STEP) && (pc_q < eff_len);
	assign op  = opcode_t'(prog_rdata[INSTR_W-1 -: OPC_W]);
	assign arg = prog_rdata[ARG_W-1:0];
	assign vm  = CP_W'(arg);
	assign tgt = {1'b0, arg} + 1'b1;

	always_comb begin
		cell_new = tape_rdata;
		cell_we  = 1'b0;
		cp_new   = cp_q;
		jump     = 1'b0;
		emit     = 1'b0;
		took     = 1'b0;
		case (op)
			OP_ADD: begin
				cell_new = tape_rdata + arg[BYTE_W-1:0];
				cell_we  = 1'b1;
			end
			OP_SUB: begin
				cell_new = tape_rdata - arg[BYTE_W-1:0];
				cell_we  = 1'b1;
			end
			OP_SET: begin
				cell_new = arg[BYTE_W-1:0];
				cell_we  = 1'b1;
			end
			OP_GOTO:       cp_new = vm;
			OP_RIGHT:      cp_new = cp_q + vm;
			OP_LEFT:       cp_new = cp_q - vm;
			OP_LOOP_START: jump = (tape_rdata == '0);
			OP_LOOP_END:   jump = (tape_rdata != '0);
			OP_WRITE:      emit = 1'b1;
			OP_READ: begin
				cell_new = in_byte_s1;
				cell_we  = 1'b1;
				took     = 1'b1;
			end
			default: ;
		endcase
	end

	// Clamp a jump past the end to the effective length
	always_comb begin
		if (!jump) begin
			pc_new = pc_q + 1'b1;
		end else if (32'(tgt) > 32'(eff_len)) begin
			pc_new = eff_len;
		end else begin
			pc_new = PC_W'(tgt);
		end
	end

	assign pc_after = run ? pc_new : pc_q;

	always_comb begin
		res_s1.out_valid  = run && emit;
		res_s1.out_byte   = (run && emit) ? tape_rdata : '0;
		res_s1.took_input = run && took;
		res_s1.halted     = (pc_after >= eff_len);
		res_s1.next_pc    = LEN_W'(pc_after);
	end

	tme_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (v_s1),
		.push_data  (res_s1),
		.pop_ready  (res_ready),
		.head_valid (res_valid),
		.head_data  (res_head),
		.full       (buf_full)
	);

	assign out_valid  = res_head.out_valid;
	assign out_byte   = res_head.out_byte;
	assign took_input = res_head.took_input;
	assign halted     = res_head.halted;
	assign next_pc    = res_head.next_pc;

endmodule

### tb/tape_machine_executor_tb.sv
// Self-checking testbench for the tape machine executor: directed table, random programs.
module tape_machine_executor_tb;
	import tme_pkg::*;

	localparam int CLK_HALF         = 4;
	localparam int RESET_CYCLES     = 9;
	// Clearing pass plus several hundred requests fit many times over in this.
	localparam int RUN_LIMIT_CYCLES = 400000;
	localparam int IDLE_PCT         = 13;
	// Covers the request in flight plus the two-entry output buffer; round up.
	localparam int SETTLE_CYCLES    = 8;
	localparam int REPORT_LIMIT     = 10;
	localparam int PHASES           = 14;
	// Window of requests/results with no random idling on either side; the long
	// receiver hold falls inside it so the block fills up and drops in_ready.
	localparam int CALM_FIRST       = 300;
	localparam int CALM_LAST        = 450;
	localparam int HOLD_AT_RESULT   = 350;
	localparam int HOLD_CYCLES      = 300;

	// Opcodes outside the defined set execute as no-ops.
	localparam logic [OPC_W-1:0] OP_SPARE_FIRST = OP_READ + 1;
	localparam logic [OPC_W-1:0] OP_SPARE_LAST  = '1;

	typedef enum logic {ROW_REQUEST, ROW_SET_LENGTH} row_kind_t;

	// One row of the directed table. For ROW_SET_LENGTH the operand column
	// carries the new program length.
	typedef struct packed {
		row_kind_t         kind;
		logic              req_cmd;
		logic [ADDR_W-1:0] addr;
		logic [OPC_W-1:0]  opc;
		logic [ARG_W-1:0]  arg;
		logic [BYTE_W-1:0] inb;
		logic              has_exp;
		result_t           exp_res;
	} directed_row_t;

	localparam result_t NO_CHECK        = '0;
	localparam result_t HALT_AT_ZERO    = '{1'b0, 8'h00, 1'b0, 1'b1, 13'd0};
	localparam result_t HALT_AT_ELEVEN  = '{1'b0, 8'h00, 1'b0, 1'b1, 13'd11};
	localparam result_t WROTE_FF_AT_SIX = '{1'b1, 8'hFF, 1'b0, 1'b0, 13'd6};
	localparam result_t READ_AT_EIGHT   = '{1'b0, 8'h00, 1'b1, 1'b0, 13'd8};

	// Directed program at addresses 0..10 with length 11:
	//   set cell to 0xFF from a full-width operand, add 1 to wrap to zero,
	//   loop start on a zero cell skips the write at 3, subtract 1 wraps back
	//   to 0xFF, write it out, step left from cell 0 to wrap the pointer to the
	//   top cell, read a byte there, move right by the largest count, go to the
	//   top cell, then loop end on a nonzero cell jumps past the end and halts.
	//   A last step while halted changes nothing.
	directed_row_t directed_rows [25] = '{
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b1, HALT_AT_ZERO},
		'{ROW_REQUEST, CMD_LOAD, 12'd4095, OP_SPARE_LAST, 15'h7FFF, 8'hFF, 1'b1, HALT_AT_ZERO},
		'{ROW_REQUEST, CMD_LOAD, 12'd0, OP_SET, 15'h7FFF, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd1, OP_ADD, 15'd1, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd2, OP_LOOP_START, 15'd3, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd3, OP_WRITE, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd4, OP_SUB, 15'd1, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd5, OP_WRITE, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd6, OP_LEFT, 15'd1, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd7, OP_READ, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd8, OP_RIGHT, 15'h7FFF, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd9, OP_GOTO, 15'h7FFF, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_LOAD, 12'd10, OP_LOOP_END, 15'd4095, 8'h00, 1'b0, NO_CHECK},
		'{ROW_SET_LENGTH, CMD_LOAD, 12'd0, OP_NOP, 15'd11, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b1, WROTE_FF_AT_SIX},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h5A, 1'b1, READ_AT_EIGHT},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b0, NO_CHECK},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b1, HALT_AT_ELEVEN},
		'{ROW_REQUEST, CMD_STEP, 12'd0, OP_NOP, 15'd0, 8'h00, 1'b1, HALT_AT_ELEVEN}
	};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [LEN_W-1:0]  cfg_wdata    = '0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic              cmd          = CMD_LOAD;
	logic [ADDR_W-1:0] load_address = '0;
	logic [OPC_W-1:0]  opcode       = OP_NOP;
	logic [ARG_W-1:0]  operand      = '0;
	logic [BYTE_W-1:0] in_byte      = '0;
	logic              res_valid;
	logic              res_ready    = 1'b0;
	logic              out_valid;
	logic [BYTE_W-1:0] out_byte;
	logic              took_input;
	logic              halted;
	logic [LEN_W-1:0]  next_pc;

	// Shadow machine state, advanced at each accepted request.
	logic [OPC_W-1:0]  prog_op      [PROG_DEPTH];
	logic [ARG_W-1:0]  prog_arg     [PROG_DEPTH];
	bit                prog_written [PROG_DEPTH];
	logic [BYTE_W-1:0] tape_cells   [TAPE_DEPTH];
	logic [CP_W-1:0]   cell_ptr;
	int unsigned       prog_ctr;
	int unsigned       prog_len;

	// Outcomes of accepted requests, oldest first, waiting for the block.
	result_t expected_results [$];

	int requests_sent = 0;
	int results_seen  = 0;
	int mismatches    = 0;
	int loads_sent    = 0;
	int steps_sent    = 0;
	int bytes_out     = 0;
	int bytes_in      = 0;
	int halted_steps  = 0;
	int length_writes = 0;

	tape_machine_executor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.load_address (load_address),
		.opcode       (opcode),
		.operand      (operand),
		.in_byte      (in_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.took_input   (took_input),
		.halted       (halted),
		.next_pc      (next_pc)
	);

	always #CLK_HALF clk = ~clk;

	// Apply one request to the shadow machine and return what the block must report.
	function automatic result_t execute_request(logic req_cmd, logic [ADDR_W-1:0] req_addr,
			logic [OPC_W-1:0] req_op, logic [ARG_W-1:0] req_arg, logic [BYTE_W-1:0] req_byte);
		result_t           res;
		int unsigned       limit;
		int unsigned       target;
		logic [OPC_W-1:0]  op;
		logic [ARG_W-1:0]  arg;
		logic [BYTE_W-1:0] cell_val;
		res = '0;
		limit = (prog_len > PROG_DEPTH) ? PROG_DEPTH : prog_len;
		if (req_cmd == CMD_LOAD) begin
			prog_op[req_addr] = req_op;
			prog_arg[req_addr] = req_arg;
			prog_written[req_addr] = 1'b1;
		end else if (prog_ctr < limit) begin
			op = prog_op[prog_ctr];
			arg = prog_arg[prog_ctr];
			cell_val = tape_cells[cell_ptr];
			target = prog_ctr + 1;
			case (op)
				OP_ADD: tape_cells[cell_ptr] = cell_val + arg[BYTE_W-1:0];
				OP_SUB: tape_cells[cell_ptr] = cell_val - arg[BYTE_W-1:0];
				OP_SET: tape_cells[cell_ptr] = arg[BYTE_W-1:0];
				// Pointer arithmetic wraps at the tape depth by truncation.
				OP_GOTO: cell_ptr = arg;
				OP_RIGHT: cell_ptr = cell_ptr + arg;
				OP_LEFT: cell_ptr = cell_ptr - arg;
				OP_LOOP_START: if (cell_val == 0) target = arg + 1;
				OP_LOOP_END: if (cell_val != 0) target = arg + 1;
				OP_WRITE: begin
					res.out_valid = 1'b1;
					res.out_byte = cell_val;
				end
				OP_READ: begin
					tape_cells[cell_ptr] = req_byte;
					res.took_input = 1'b1;
				end
				default: ;
			endcase
			// A jump past the end lands on the end and halts.
			prog_ctr = (target > limit) ? limit : target;
		end
		res.halted = prog_ctr >= limit;
		res.next_pc = LEN_W'(prog_ctr);
		return res;
	endfunction

	// Offer one request, hold it until accepted, then log its expected outcome.
	// Called and returns at a falling edge; valid stays high for a following request.
	task automatic send_request(logic req_cmd, logic [ADDR_W-1:0] req_addr,
			logic [OPC_W-1:0] req_op, logic [ARG_W-1:0] req_arg, logic [BYTE_W-1:0] req_byte,
			logic use_typed, result_t typed_res);
		result_t predicted;
		bit      calm;
		calm = requests_sent >= CALM_FIRST && requests_sent < CALM_LAST;
		while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= req_cmd;
		load_address <= req_addr;
		opcode <= req_op;
		operand <= req_arg;
		in_byte <= req_byte;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = execute_request(req_cmd, req_addr, req_op, req_arg, req_byte);
		expected_results.insert(expected_results.size(), use_typed ? typed_res : predicted);
		requests_sent++;
		if (req_cmd == CMD_LOAD) begin
			loads_sent++;
		end else begin
			steps_sent++;
			bytes_out += predicted.out_valid;
			bytes_in += predicted.took_input;
			halted_steps += predicted.halted;
		end
		@(negedge clk);
	endtask

	// Drop valid and wait until every outstanding result has come back.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_program_length(logic [LEN_W-1:0] len);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		prog_len = len;
		length_writes++;
	endtask

	// Result side: random back-pressure, one long hold, and a calm stretch.
	initial begin : result_pacer
		bit held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AT_RESULT) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (results_seen >= CALM_FIRST && results_seen < CALM_LAST)
				res_ready <= 1'b1;
			else
				res_ready <= ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Compare every accepted result with the oldest expectation, field by field.
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		bit      bad;
		if (res_valid === 1'b1 && res_ready === 1'b1) begin
			got = '{out_valid, out_byte, took_input, halted, next_pc};
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result %0d: valid=%0b byte=%02h took=%0b halted=%0b pc=%0d",
						results_seen, got.out_valid, got.out_byte, got.took_input, got.halted,
						got.next_pc);
			end else begin
				want = expected_results.pop_front();
				bad = got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
					got.took_input !== want.took_input || got.halted !== want.halted ||
					got.next_pc !== want.next_pc;
				if (bad) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("result %0d mismatch: expected valid=%0b byte=%02h took=%0b halted=%0b pc=%0d",
							results_seen, want.out_valid, want.out_byte, want.took_input,
							want.halted, want.next_pc);
						$display("                      got valid=%0b byte=%02h took=%0b halted=%0b pc=%0d",
							got.out_valid, got.out_byte, got.took_input, got.halted, got.next_pc);
					end
				end
			end
		end
	end

	initial begin : watchdog
		#(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
		$display("tape_machine_executor regression: fail");
		$finish;
	end

	initial begin : stimulus
		int               base;
		int               span;
		int               next_len;
		int               n_steps;
		int               pick;
		int               tgt;
		int unsigned      run_len;
		bit               wide;
		bit               looped;
		logic [OPC_W-1:0] op;
		logic [ARG_W-1:0] arg;

		for (int i = 0; i < TAPE_DEPTH; i++)
			tape_cells[i] = '0;
		cell_ptr = '0;
		prog_ctr = 0;
		prog_len = 0;

		// Hold reset, then release at a falling edge. The clearing pass that
		// follows keeps in_ready low; the first request simply waits it out.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SET_LENGTH) begin
				wait_until_idle();
				set_program_length(directed_rows[i].arg[LEN_W-1:0]);
			end else begin
				send_request(directed_rows[i].req_cmd, directed_rows[i].addr,
					directed_rows[i].opc, directed_rows[i].arg, directed_rows[i].inb,
					directed_rows[i].has_exp, directed_rows[i].exp_res);
			end
		end

		// Random phases. The counter never resets, so each phase writes a short
		// program at the current counter and sets the length to cover it. Special
		// phases: zero length, all-ones length (saturates), full depth, and a
		// length below the counter.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_until_idle();
			base = prog_ctr;
			span = $urandom_range(20, 6);
			if (ph == PHASES - 3 || ph == PHASES - 2)
				span = 24;
			if (span > PROG_DEPTH - base)
				span = PROG_DEPTH - base;
			case (ph)
				1: next_len = 0;
				PHASES - 3: next_len = (1 << LEN_W) - 1;
				PHASES - 2: next_len = PROG_DEPTH;
				PHASES - 1: next_len = base / 2;
				default: next_len = base + span;
			endcase
			set_program_length(LEN_W'(next_len));

			// Optionally open with a counted loop: set n, [ write, sub 1 ].
			looped = span >= 6 && $urandom_range(1, 0) == 1;
			for (int k = 0; k < span; k++) begin
				pick = $urandom_range(99, 0);
				wide = $urandom_range(9, 0) == 0;
				tgt = base + $urandom_range(span - 1, 0);
				arg = wide ? ARG_W'($urandom) : ARG_W'($urandom_range(255, 0));
				if (pick < 14) begin
					op = OP_ADD;
				end else if (pick < 26) begin
					op = OP_SUB;
				end else if (pick < 34) begin
					op = OP_SET;
					arg = ARG_W'($urandom);
				end else if (pick < 40) begin
					op = OP_GOTO;
					arg = wide ? ARG_W'($urandom) : ARG_W'($urandom_range(7, 0));
				end else if (pick < 50) begin
					op = OP_RIGHT;
					arg = wide ? ARG_W'($urandom) : ARG_W'($urandom_range(3, 0));
				end else if (pick < 60) begin
					op = OP_LEFT;
					arg = wide ? ARG_W'($urandom) : ARG_W'($urandom_range(3, 0));
				end else if (pick < 68) begin
					op = OP_LOOP_START;
					arg = wide ? ARG_W'($urandom) : ARG_W'(tgt);
				end else if (pick < 76) begin
					op = OP_LOOP_END;
					arg = wide ? ARG_W'($urandom) : ARG_W'(tgt);
				end else if (pick < 86) begin
					op = OP_WRITE;
				end else if (pick < 94) begin
					op = OP_READ;
				end else begin
					op = wide ? OP_NOP : OP_SPARE_FIRST + OPC_W'($urandom_range(4, 0));
				end
				if (looped && k < 5) begin
					case (k)
						0: begin
							op = OP_SET;
							arg = ARG_W'($urandom_range(5, 1));
						end
						1: begin
							op = OP_LOOP_START;
							arg = ARG_W'(base + 4);
						end
						2: op = OP_WRITE;
						3: begin
							op = OP_SUB;
							arg = ARG_W'(1);
						end
						default: begin
							op = OP_LOOP_END;
							arg = ARG_W'(base + 1);
						end
					endcase
				end
				send_request(CMD_LOAD, ADDR_W'(base + k), op, arg, BYTE_W'($urandom),
					1'b0, NO_CHECK);
			end

			// Run it, with the odd stray load mixed in while running. When the
			// counter sits on an entry that was never loaded, load it first.
			n_steps = (next_len > base) ? 2 * span + $urandom_range(12, 4) : 12;
			if (ph == PHASES - 3)
				n_steps = 80;
			repeat (n_steps) begin
				run_len = (prog_len > PROG_DEPTH) ? PROG_DEPTH : prog_len;
				if (prog_ctr < run_len && !prog_written[prog_ctr])
					send_request(CMD_LOAD, ADDR_W'(prog_ctr), OPC_W'($urandom),
						ARG_W'($urandom), BYTE_W'($urandom), 1'b0, NO_CHECK);
				else
					send_request(($urandom_range(9, 0) == 0) ? CMD_LOAD : CMD_STEP,
						ADDR_W'($urandom), OPC_W'($urandom), ARG_W'($urandom),
						BYTE_W'($urandom), 1'b0, NO_CHECK);
			end
		end

		wait_until_idle();
		$display("covered %0d requests: %0d loads, %0d steps, %0d bytes out, %0d bytes in",
			requests_sent, loads_sent, steps_sent, bytes_out, bytes_in);
		$display("%0d steps ended halted, %0d length settings, %0d mismatches",
			halted_steps, length_writes, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tape_machine_executor regression: pass");
		else
			$display("tape_machine_executor regression: fail");
		$finish;
	end

endmodule

### filelist.f
design/tme_pkg.sv
design/tme_ram.sv
design/tme_out_buf.sv
design/tape_machine_executor.sv
tb/tape_machine_executor_tb.sv
